@@ rtl/lav_pkg.sv @@
package lav_pkg;

  localparam int unsigned FracBits = 16;
  // magnitude width of a vector entering the normalizer (difference or cross product)
  localparam int unsigned NvW = FracBits + 34;
  localparam int unsigned AxW = FracBits + 2;
  localparam int unsigned QW = FracBits + 1;
  localparam int unsigned RemW = FracBits + 32;
  localparam int unsigned BitsW = $clog2(NvW + 1);
  localparam int unsigned NormShift = 30;
  localparam int unsigned SqSteps = 32;
  localparam int unsigned SqPerStg = 2;
  localparam int unsigned SqStg = SqSteps / SqPerStg;
  localparam int unsigned NormLat = 5 + SqStg + 1 + QW + 1;

  typedef enum logic [1:0] {
    ROW_RIGHT = 2'd0,
    ROW_UP    = 2'd1,
    ROW_FWD   = 2'd2
  } row_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
    logic               degenerate;
  } out_t;

  typedef logic [2:0][NvW-1:0] nvec_t;
  typedef logic [2:0][AxW-1:0] axvec_t;

  // three rows of one matrix: axis[row][component], row order right, up, forward
  typedef struct packed {
    logic [2:0][2:0][31:0] axis;
    logic [2:0][31:0]      col3;
    logic                  degen;
  } rowset_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sq_t;

  // one digit of the bit-pair integer square root
  function automatic sq_t sq_step(sq_t s, int unsigned j);
    logic [63:0] b;
    logic [63:0] t;
    sq_t         o;
    b = 64'd1 << (62 - 2 * j);
    t = s.r + b;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // 2*FracBits fraction bits down to FracBits, half away from zero
  function automatic logic signed [63:0] round_frac(logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? (64'd0 - 64'(x)) : 64'(x);
    r = (mag + (64'd1 << (FracBits - 1))) >> FracBits;
    return x[63] ? $signed(64'd0 - r) : $signed(r);
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/lav_norm.sv @@
module lav_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  lav_pkg::nvec_t  vec_i,
  output logic            vld_o,
  output logic            ok_o,
  output lav_pkg::axvec_t unit_o
);

  localparam int unsigned NvW = lav_pkg::NvW;
  localparam int unsigned BitsW = lav_pkg::BitsW;
  localparam int unsigned RemW = lav_pkg::RemW;
  localparam int unsigned QW = lav_pkg::QW;
  localparam int unsigned AxW = lav_pkg::AxW;
  localparam int unsigned SqStg = lav_pkg::SqStg;
  localparam int unsigned Sh = lav_pkg::NormShift;

  typedef struct packed {
    logic [2:0][Sh-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
  } cy_t;

  typedef struct packed {
    logic [2:0][RemW-1:0] rem;
    logic [2:0][QW-1:0]   q;
    logic [30:0]          len;
    logic [2:0]           neg;
    logic                 zero;
  } dv_t;

  // stage 1: magnitudes and largest
  logic                  s1_vld_q;
  logic [2:0][NvW-1:0]   s1_mag_q, s1_mag_d;
  logic [2:0]            s1_neg_q, s1_neg_d;
  logic [NvW-1:0]        s1_max_q, s1_max_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_d[i] = vec_i[i][NvW-1];
      s1_mag_d[i] = s1_neg_d[i] ? (NvW'(0) - vec_i[i]) : vec_i[i];
    end
    s1_max_d = (s1_mag_d[0] > s1_mag_d[1]) ? s1_mag_d[0] : s1_mag_d[1];
    if (s1_mag_d[2] > s1_max_d) begin
      s1_max_d = s1_mag_d[2];
    end
  end

  // stage 2: leading one position
  logic                s2_vld_q;
  logic [2:0][NvW-1:0] s2_mag_q;
  logic [2:0]          s2_neg_q;
  logic [BitsW-1:0]    s2_bits_q, s2_bits_d;
  logic                s2_zero_q;

  always_comb begin
    s2_bits_d = '0;
    for (int i = 0; i < NvW; i++) begin
      if (s1_max_q[i]) begin
        s2_bits_d = BitsW'(i + 1);
      end
    end
  end

  // stage 3: common shift, largest lands in [2^29, 2^30)
  logic s3_vld_q;
  cy_t  s3_cy_q, s3_cy_d;

  always_comb begin
    logic [NvW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (s2_bits_q > BitsW'(Sh)) begin
        sh = s2_mag_q[i] >> (s2_bits_q - BitsW'(Sh));
      end else begin
        sh = s2_mag_q[i] << (BitsW'(Sh) - s2_bits_q);
      end
      s3_cy_d.mag[i] = sh[Sh-1:0];
    end
    s3_cy_d.neg = s2_neg_q;
    s3_cy_d.zero = s2_zero_q;
  end

  // stage 4: squares
  logic              s4_vld_q;
  cy_t               s4_cy_q;
  logic [2:0][59:0]  s4_sq_q, s4_sq_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_sq_d[i] = 60'(s3_cy_q.mag[i]) * 60'(s3_cy_q.mag[i]);
    end
  end

  // stage 5: sum of squares
  logic         s5_vld_q;
  cy_t          s5_cy_q;
  lav_pkg::sq_t s5_sq_q, s5_sq_d;

  always_comb begin
    s5_sq_d.x = 64'(s4_sq_q[0]) + 64'(s4_sq_q[1]) + 64'(s4_sq_q[2]);
    s5_sq_d.r = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mag_q  <= s1_mag_d;
      s1_neg_q  <= s1_neg_d;
      s1_max_q  <= s1_max_d;
      s2_mag_q  <= s1_mag_q;
      s2_neg_q  <= s1_neg_q;
      s2_bits_q <= s2_bits_d;
      s2_zero_q <= (s1_max_q == '0);
      s3_cy_q   <= s3_cy_d;
      s4_cy_q   <= s3_cy_q;
      s4_sq_q   <= s4_sq_d;
      s5_cy_q   <= s4_cy_q;
      s5_sq_q   <= s5_sq_d;
    end
  end

  // square root, two digits per stage
  lav_pkg::sq_t sq_q  [SqStg];
  cy_t          sqc_q [SqStg];
  logic         sqv_q [SqStg];

  for (genvar k = 0; k < SqStg; k++) begin : g_sq
    lav_pkg::sq_t st_in;
    lav_pkg::sq_t st_d;
    cy_t          cy_in;
    logic         v_in;

    if (k == 0) begin : g_first
      assign st_in = s5_sq_q;
      assign cy_in = s5_cy_q;
      assign v_in  = s5_vld_q;
    end else begin : g_next
      assign st_in = sq_q[k-1];
      assign cy_in = sqc_q[k-1];
      assign v_in  = sqv_q[k-1];
    end

    always_comb begin
      st_d = st_in;
      for (int j = 0; j < lav_pkg::SqPerStg; j++) begin
        st_d = lav_pkg::sq_step(st_d, lav_pkg::SqPerStg * k + j);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k] <= 1'b0;
      end else if (en_i) begin
        sqv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k]  <= st_d;
        sqc_q[k] <= cy_in;
      end
    end
  end

  // divider setup: (mag << FracBits) + len/2
  logic        pr_vld_q;
  dv_t         pr_q, pr_d;
  logic [30:0] len;

  assign len = sq_q[SqStg-1].r[30:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_d.rem[i] = (RemW'(sqc_q[SqStg-1].mag[i]) << lav_pkg::FracBits) + RemW'(len >> 1);
    end
    pr_d.q = '0;
    pr_d.len = len;
    pr_d.neg = sqc_q[SqStg-1].neg;
    pr_d.zero = sqc_q[SqStg-1].zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else if (en_i) begin
      pr_vld_q <= sqv_q[SqStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= pr_d;
    end
  end

  // restoring divider, one quotient bit per stage
  dv_t  dv_q [QW];
  logic dvv_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_dv
    dv_t  dv_in;
    dv_t  dv_d;
    logic v_in;

    if (k == 0) begin : g_first
      assign dv_in = pr_q;
      assign v_in  = pr_vld_q;
    end else begin : g_next
      assign dv_in = dv_q[k-1];
      assign v_in  = dvv_q[k-1];
    end

    always_comb begin
      logic [RemW-1:0] dvs;
      dvs = RemW'(dv_in.len) << (QW - 1 - k);
      dv_d = dv_in;
      for (int i = 0; i < 3; i++) begin
        if (dv_in.rem[i] >= dvs) begin
          dv_d.rem[i] = dv_in.rem[i] - dvs;
          dv_d.q[i] = {dv_in.q[i][QW-2:0], 1'b1};
        end else begin
          dv_d.q[i] = {dv_in.q[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k] <= 1'b0;
      end else if (en_i) begin
        dvv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= dv_d;
      end
    end
  end

  // sign and zero-length mask
  lav_pkg::axvec_t unit_d;
  dv_t             dl;

  assign dl = dv_q[QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dl.zero) begin
        unit_d[i] = '0;
      end else if (dl.neg[i]) begin
        unit_d[i] = AxW'(0) - AxW'(dl.q[i]);
      end else begin
        unit_d[i] = AxW'(dl.q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= dvv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit_o <= unit_d;
      ok_o   <= !dl.zero;
    end
  end

endmodule

@@ rtl/lav_rows.sv @@
module lav_rows (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ld_i,
  input  lav_pkg::rowset_t rows_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lav_pkg::out_t    out_word_o
);

  logic             busy_q;
  lav_pkg::row_e    row_q;
  lav_pkg::rowset_t set_q;
  logic             take;
  logic             last;

  assign take = busy_q && !out_stall_i;
  assign last = (row_q == lav_pkg::ROW_FWD);
  assign free_o = !busy_q || (take && last);
  assign out_valid_o = busy_q;

  always_comb begin
    out_word_o.row_index  = row_q;
    out_word_o.col0       = set_q.axis[row_q][0];
    out_word_o.col1       = set_q.axis[row_q][1];
    out_word_o.col2       = set_q.axis[row_q][2];
    out_word_o.col3       = set_q.col3[row_q];
    out_word_o.last_row   = last;
    out_word_o.degenerate = set_q.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= lav_pkg::ROW_RIGHT;
    end else if (ld_i) begin
      busy_q <= 1'b1;
      row_q  <= lav_pkg::ROW_RIGHT;
    end else if (take) begin
      unique case (row_q)
        lav_pkg::ROW_RIGHT: row_q <= lav_pkg::ROW_UP;
        lav_pkg::ROW_UP:    row_q <= lav_pkg::ROW_FWD;
        default: begin
          busy_q <= 1'b0;
          row_q  <= lav_pkg::ROW_RIGHT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      set_q <= rows_i;
    end
  end

endmodule

@@ rtl/look_at_view_matrix.sv @@
// Channel  Dir  Handshake               Word
// input    in   in_valid_i / in_stall_o   in_word_i  (position, target, up)
// output   out  out_valid_o / out_stall_i out_word_o (one matrix row)
//
// Each input word gives three output words (right, up, forward rows).
// The single output port sets the sustained input rate: three rows per input word.
// The path to the first row runs mostly through the two normalizers (square root
// at 2 digits/stage, divider at 1 bit/stage). The whole pipeline advances together;
// a stalled output freezes it once its last stage holds a word; nothing is lost.
// Reset clears all valid bits and the row sequencer.
module look_at_view_matrix (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lav_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lav_pkg::out_t out_word_o
);

  localparam int unsigned NvW = lav_pkg::NvW;
  localparam int unsigned AxW = lav_pkg::AxW;
  localparam int unsigned NormLat = lav_pkg::NormLat;

  typedef logic [2:0][31:0] v32_t;
  typedef struct packed {
    v32_t p;
    v32_t up;
  } side_a_t;
  typedef struct packed {
    v32_t            p;
    lav_pkg::axvec_t f;
    logic            okf;
  } side_b_t;

  logic adv;
  logic free;
  logic d3_vld_q;

  assign adv = !d3_vld_q || free;
  assign in_stall_o = !adv;

  // input stage
  logic           s0_vld_q;
  v32_t           s0_p_q, s0_u_q;
  lav_pkg::nvec_t s0_d_q, s0_d_d;

  always_comb begin
    s0_d_d[0] = NvW'(in_word_i.pos_x) - NvW'(in_word_i.target_x);
    s0_d_d[1] = NvW'(in_word_i.pos_y) - NvW'(in_word_i.target_y);
    s0_d_d[2] = NvW'(in_word_i.pos_z) - NvW'(in_word_i.target_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_p_q <= {in_word_i.pos_z, in_word_i.pos_y, in_word_i.pos_x};
      s0_u_q <= {in_word_i.up_z, in_word_i.up_y, in_word_i.up_x};
      s0_d_q <= s0_d_d;
    end
  end

  // forward axis
  logic            nf_vld, nf_ok;
  lav_pkg::axvec_t nf_unit;

  lav_norm u_norm_f (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s0_vld_q),
    .vec_i  (s0_d_q),
    .vld_o  (nf_vld),
    .ok_o   (nf_ok),
    .unit_o (nf_unit)
  );

  side_a_t sa_q [NormLat];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q[0] <= {s0_p_q, s0_u_q};
      for (int i = 1; i < NormLat; i++) begin
        sa_q[i] <= sa_q[i-1];
      end
    end
  end

  // cross(up, f): products then differences
  side_a_t                  sa;
  logic                     c1_vld_q, c2_vld_q;
  logic signed [31+AxW:0]   c1_m_q [6];
  logic signed [31+AxW:0]   c1_m_d [6];
  v32_t                     c1_p_q, c2_p_q;
  lav_pkg::axvec_t          c1_f_q, c2_f_q;
  logic                     c1_ok_q, c2_ok_q;
  lav_pkg::nvec_t           c2_c_q, c2_c_d;

  assign sa = sa_q[NormLat-1];

  always_comb begin
    c1_m_d[0] = $signed(sa.up[1]) * $signed(nf_unit[2]);
    c1_m_d[1] = $signed(sa.up[2]) * $signed(nf_unit[1]);
    c1_m_d[2] = $signed(sa.up[2]) * $signed(nf_unit[0]);
    c1_m_d[3] = $signed(sa.up[0]) * $signed(nf_unit[2]);
    c1_m_d[4] = $signed(sa.up[0]) * $signed(nf_unit[1]);
    c1_m_d[5] = $signed(sa.up[1]) * $signed(nf_unit[0]);
    // packed vectors hold x at index 0, z at index 2
    c2_c_d[0] = NvW'(c1_m_q[0] - c1_m_q[1]);
    c2_c_d[1] = NvW'(c1_m_q[2] - c1_m_q[3]);
    c2_c_d[2] = NvW'(c1_m_q[4] - c1_m_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
    end else if (adv) begin
      c1_vld_q <= nf_vld;
      c2_vld_q <= c1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_m_q  <= c1_m_d;
      c1_p_q  <= sa.p;
      c1_f_q  <= nf_unit;
      c1_ok_q <= nf_ok;
      c2_c_q  <= c2_c_d;
      c2_p_q  <= c1_p_q;
      c2_f_q  <= c1_f_q;
      c2_ok_q <= c1_ok_q;
    end
  end

  // right axis
  logic            nr_vld, nr_ok;
  lav_pkg::axvec_t nr_unit;

  lav_norm u_norm_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (c2_vld_q),
    .vec_i  (c2_c_q),
    .vld_o  (nr_vld),
    .ok_o   (nr_ok),
    .unit_o (nr_unit)
  );

  side_b_t sb_q [NormLat];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= {c2_p_q, c2_f_q, c2_ok_q};
      for (int i = 1; i < NormLat; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // true up = cross(f, r), rounded
  side_b_t                  sb;
  logic                     v1_vld_q, v2_vld_q;
  logic signed [2*AxW-1:0]  v1_m_q [6];
  logic signed [2*AxW-1:0]  v1_m_d [6];
  v32_t                     v1_p_q, v2_p_q;
  lav_pkg::axvec_t          v1_f_q, v1_r_q;
  logic                     v1_dg_q, v2_dg_q;
  logic [2:0][2:0][31:0]    v2_ax_q, v2_ax_d;

  assign sb = sb_q[NormLat-1];

  always_comb begin
    v1_m_d[0] = $signed(sb.f[1]) * $signed(nr_unit[2]);
    v1_m_d[1] = $signed(sb.f[2]) * $signed(nr_unit[1]);
    v1_m_d[2] = $signed(sb.f[2]) * $signed(nr_unit[0]);
    v1_m_d[3] = $signed(sb.f[0]) * $signed(nr_unit[2]);
    v1_m_d[4] = $signed(sb.f[0]) * $signed(nr_unit[1]);
    v1_m_d[5] = $signed(sb.f[1]) * $signed(nr_unit[0]);
    for (int i = 0; i < 3; i++) begin
      v2_ax_d[lav_pkg::ROW_RIGHT][i] = 32'($signed(v1_r_q[i]));
      v2_ax_d[lav_pkg::ROW_FWD][i]   = 32'($signed(v1_f_q[i]));
    end
    v2_ax_d[lav_pkg::ROW_UP][0] = 32'(lav_pkg::round_frac(64'(v1_m_q[0]) - 64'(v1_m_q[1])));
    v2_ax_d[lav_pkg::ROW_UP][1] = 32'(lav_pkg::round_frac(64'(v1_m_q[2]) - 64'(v1_m_q[3])));
    v2_ax_d[lav_pkg::ROW_UP][2] = 32'(lav_pkg::round_frac(64'(v1_m_q[4]) - 64'(v1_m_q[5])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_vld_q <= 1'b0;
      v2_vld_q <= 1'b0;
    end else if (adv) begin
      v1_vld_q <= nr_vld;
      v2_vld_q <= v1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_m_q  <= v1_m_d;
      v1_p_q  <= sb.p;
      v1_f_q  <= sb.f;
      v1_r_q  <= nr_unit;
      v1_dg_q <= !(sb.okf && nr_ok);
      v2_ax_q <= v2_ax_d;
      v2_p_q  <= v1_p_q;
      v2_dg_q <= v1_dg_q;
    end
  end

  // translation column: products, negated sum, round and saturate
  logic                   d1_vld_q, d2_vld_q;
  logic signed [63:0]     d1_m_q [9];
  logic signed [63:0]     d1_m_d [9];
  logic signed [63:0]     d2_n_q [3];
  logic signed [63:0]     d2_n_d [3];
  logic [2:0][2:0][31:0]  d1_ax_q, d2_ax_q;
  logic                   d1_dg_q, d2_dg_q;
  lav_pkg::rowset_t       d3_q, d3_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        d1_m_d[3*k+i] = $signed(v2_ax_q[k][i]) * $signed(v2_p_q[i]);
      end
      d2_n_d[k] = 64'sd0 - (d1_m_q[3*k] + d1_m_q[3*k+1] + d1_m_q[3*k+2]);
    end
    d3_d.axis = d2_ax_q;
    d3_d.degen = d2_dg_q;
    for (int k = 0; k < 3; k++) begin
      d3_d.col3[k] = lav_pkg::sat32(lav_pkg::round_frac(d2_n_q[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
      d3_vld_q <= 1'b0;
    end else if (adv) begin
      d1_vld_q <= v2_vld_q;
      d2_vld_q <= d1_vld_q;
      d3_vld_q <= d2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_m_q  <= d1_m_d;
      d1_ax_q <= v2_ax_q;
      d1_dg_q <= v2_dg_q;
      d2_n_q  <= d2_n_d;
      d2_ax_q <= d1_ax_q;
      d2_dg_q <= d1_dg_q;
      d3_q    <= d3_d;
    end
  end

  lav_rows u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (d3_vld_q && free),
    .rows_i      (d3_q),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
